/* hw/rtl/swat_pkg.sv */
// shared constants and types for the sender window acknowledgement tracker
`timescale 1ns / 1ps

package swat_pkg;

    localparam int WINDOW     = 16;
    localparam int RING_SLOTS = 2 * WINDOW;
    localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);
    localparam int SHOW_BITS  = (RING_SLOTS < 32) ? RING_SLOTS : 32;
    localparam int ADV_W      = 5;

    localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
    localparam logic [1:0] STAT_STALE     = 2'd1;
    localparam logic [1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [1:0] STAT_BEYOND    = 2'd3;

    typedef struct packed {
        logic              mark;
        logic [SLOT_W-1:0] slot;
    } scan_ctrl_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [31:0]           base;
        logic [SLOT_W-1:0]     base_slot;
        logic [RING_SLOTS-1:0] bitmap;
        logic [CNT_W-1:0]      count;
    } scan_stat_t;

endpackage

/* hw/rtl/sender_window_ack_tracker_core.sv */
// top level of the sender window acknowledgement tracker
`timescale 1ns / 1ps

// Sender side of a selective-repeat window. Each input beat carries one
// acknowledged frame number; each one yields exactly one result beat with the
// status in m_tuser, transfer done on m_tlast, and the new base, advance count
// and ring bitmap in m_tdata. A rejected acknowledgement (stale, duplicate or
// beyond the window) goes from the idle state to the emit state and is loaded
// into the result register from there once that register is free, after which
// the next input beat can be taken in the idle state; an accepted one first
// passes through the scan state, where the advance engine inspects and clears
// one ring slot per cycle and moves the base by at most the window size, 16
// frames. A result beat that waits on m_tready holds the next one back until
// the output register is free. One acknowledgement is in work at a time; the
// next one is taken while the result beat still waits on the output.
// total_frames sits at byte address 0 of the configuration port.

module sender_window_ack_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] ack_frame
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] base_after, [36:32] advance_count,
                                   // [68:37] ack_bitmap, [71:69] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // transfer_done
);
    import swat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [31:0]       total_reg;
    logic [1:0]        stat_reg, stat_next;
    logic [1:0]        cls_status;
    logic [SLOT_W-1:0] cls_slot;
    scan_ctrl_t        ctrl;
    scan_stat_t        stat;
    logic              in_beat;
    logic              out_free;
    logic              load_out;
    logic [31:0]       show_bitmap;
    logic [ADV_W-1:0]  adv;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [31:0]       m_base_reg;
    logic [ADV_W-1:0]  m_adv_reg;
    logic [31:0]       m_bitmap_reg;
    logic              m_done_reg;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? total_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            total_reg <= pwdata;
        end
    end

    swat_classify u_classify (
        .frame     (s_tdata),
        .base      (stat.base),
        .base_slot (stat.base_slot),
        .bitmap    (stat.bitmap),
        .status    (cls_status),
        .slot      (cls_slot)
    );

    swat_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign ctrl.mark = in_beat && (cls_status == STAT_ACCEPTED);
    assign ctrl.slot = cls_slot;
    assign out_free  = !m_valid_reg || m_tready;
    assign load_out  = (state_reg == S_EMIT) && out_free;

    always_comb begin
        state_next = state_reg;
        stat_next  = stat_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    stat_next  = cls_status;
                    state_next = (cls_status == STAT_ACCEPTED) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (stat.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stat_reg  <= STAT_ACCEPTED;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb begin
        show_bitmap = '0;
        for (int i = 0; i < SHOW_BITS; i++) begin
            show_bitmap[i] = stat.bitmap[i];
        end
    end

    always_comb begin
        if (stat_reg != STAT_ACCEPTED) begin
            adv = '0;
        end else if (32'(stat.count) > 32'd31) begin
            adv = ADV_W'(31);
        end else begin
            adv = ADV_W'(stat.count);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= stat_reg;
            m_base_reg   <= stat.base;
            m_adv_reg    <= adv;
            m_bitmap_reg <= show_bitmap;
            m_done_reg   <= (stat.base == total_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_bitmap_reg, m_adv_reg, m_base_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_done_reg;

`ifndef SYNTHESIS
    a_adv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (32'(m_adv_reg) <= 32'(WINDOW)))
        else $error("advance count beyond window");

    a_reject_no_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_ACCEPTED) |-> (m_adv_reg == '0))
        else $error("rejected beat reports an advance");

    a_scan_only_after_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !stat.busy)
        else $error("advance engine busy while idle");

    a_mark_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.mark |=> (state_reg == S_SCAN && stat.busy))
        else $error("accepted beat did not start a scan");
`endif

endmodule

/* hw/rtl/swat_classify.sv */
// classifies an acknowledged frame against the window and finds its ring slot
`timescale 1ns / 1ps

module swat_classify (
    input  logic [31:0]                     frame,
    input  logic [31:0]                     base,
    input  logic [swat_pkg::SLOT_W-1:0]     base_slot,
    input  logic [swat_pkg::RING_SLOTS-1:0] bitmap,
    output logic [1:0]                      status,
    output logic [swat_pkg::SLOT_W-1:0]     slot
);
    import swat_pkg::*;

    logic [32:0]     diff;
    logic            stale;
    logic            beyond;
    logic [SLOT_W:0] slot_sum;

    assign diff     = {1'b0, frame} - {1'b0, base};
    assign stale    = diff[32];
    assign beyond   = diff[31:0] >= 32'(WINDOW);
    assign slot_sum = {1'b0, base_slot} + {1'b0, diff[SLOT_W-1:0]};

    always_comb begin
        if (slot_sum >= (SLOT_W + 1)'(RING_SLOTS)) begin
            slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(RING_SLOTS));
        end else begin
            slot = slot_sum[SLOT_W-1:0];
        end
    end

    always_comb begin
        priority if (stale) begin
            status = STAT_STALE;
        end else if (beyond) begin
            status = STAT_BEYOND;
        end else if (bitmap[slot]) begin
            status = STAT_DUPLICATE;
        end else begin
            status = STAT_ACCEPTED;
        end
    end

endmodule

/* hw/rtl/swat_scan.sv */
// window state and the serial base advance engine, one ring slot per cycle
`timescale 1ns / 1ps

module swat_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  swat_pkg::scan_ctrl_t ctrl,
    output swat_pkg::scan_stat_t stat
);
    import swat_pkg::*;

    logic [31:0]           base_reg, base_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [RING_SLOTS-1:0] bitmap_reg, bitmap_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  busy_reg, busy_next;
    logic                  step;

    assign step = busy_reg && bitmap_reg[slot_reg] && (count_reg != CNT_W'(RING_SLOTS));

    always_comb begin
        base_next   = base_reg;
        slot_next   = slot_reg;
        bitmap_next = bitmap_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        if (ctrl.mark) begin
            bitmap_next[ctrl.slot] = 1'b1;
            count_next             = '0;
            busy_next              = 1'b1;
        end else if (step) begin
            bitmap_next[slot_reg] = 1'b0;
            base_next             = base_reg + 32'd1;
            count_next            = count_reg + CNT_W'(1);
            if (base_reg == 32'hFFFF_FFFF || slot_reg == SLOT_W'(RING_SLOTS - 1)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end else if (busy_reg) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            slot_reg   <= '0;
            bitmap_reg <= '0;
            count_reg  <= '0;
            busy_reg   <= 1'b0;
        end else begin
            base_reg   <= base_next;
            slot_reg   <= slot_next;
            bitmap_reg <= bitmap_next;
            count_reg  <= count_next;
            busy_reg   <= busy_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = busy_reg && !step;
    assign stat.base      = base_reg;
    assign stat.base_slot = slot_reg;
    assign stat.bitmap    = bitmap_reg;
    assign stat.count     = count_reg;

endmodule
